>>> hdl/gpe_pkg.sv
// ----------------------------------------------------------------------------
// gpe_pkg
// Shared types and constants for the GPIO bank with event detection.
// ----------------------------------------------------------------------------
package gpe_pkg;

    localparam int unsigned PIN_COUNT = 32;

    localparam logic [31:0] PIN_MASK = 32'((64'd1 << PIN_COUNT) - 64'd1);

    localparam int unsigned FSEL_PINS_PER_WORD = 10;
    localparam int unsigned PULL_PINS_PER_WORD = 16;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [5:0] W_FSEL0   = 6'd0;
    localparam logic [5:0] W_FSEL1   = 6'd1;
    localparam logic [5:0] W_FSEL2   = 6'd2;
    localparam logic [5:0] W_FSEL3   = 6'd3;
    localparam logic [5:0] W_SET     = 6'd7;
    localparam logic [5:0] W_CLR     = 6'd10;
    localparam logic [5:0] W_LEV     = 6'd13;
    localparam logic [5:0] W_EDS     = 6'(8'h40 / 4);
    localparam logic [5:0] W_REN     = 6'(8'h4c / 4);
    localparam logic [5:0] W_FEN     = 6'(8'h58 / 4);
    localparam logic [5:0] W_HEN     = 6'(8'h64 / 4);
    localparam logic [5:0] W_LEN     = 6'(8'h70 / 4);
    localparam logic [5:0] W_PULL_LO = 6'd57;
    localparam logic [5:0] W_PULL_HI = 6'd58;

    localparam logic [2:0] FSEL_OUTPUT = 3'd1;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [5:0]  word_address;
        logic [31:0] write_data;
        logic [31:0] pin_levels;
    } t_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq;
        logic [31:0] pin_drive;
        logic [31:0] pin_output_enable;
        logic [63:0] pad_pulls;
    } t_result;

endpackage

>>> hdl/gpe_regs.sv
// ----------------------------------------------------------------------------
// gpe_regs
// Register file, event detection and result formation for one transfer.
// ----------------------------------------------------------------------------
module gpe_regs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  gpe_pkg::t_item  i_item,
    output gpe_pkg::t_result o_result
);
    import gpe_pkg::*;

    logic [PIN_COUNT-1:0][2:0] r_fsel, n_fsel;
    logic [PIN_COUNT-1:0][1:0] r_pull, n_pull;
    logic [31:0] r_latch,  n_latch;
    logic [31:0] r_sample, n_sample;
    logic [31:0] r_status, n_status;
    logic [31:0] r_ren, n_ren;
    logic [31:0] r_fen, n_fen;
    logic [31:0] r_hen, n_hen;
    logic [31:0] r_len, n_len;

    logic        wr;
    logic [31:0] lev_s;
    logic [31:0] ev;
    logic [31:0] fsel_rd;
    logic [31:0] pull_rd;
    logic [31:0] rd;
    logic [31:0] oe;
    logic [63:0] pulls;

    assign wr    = (i_item.opcode == OP_WRITE);
    assign lev_s = i_item.pin_levels & PIN_MASK;
    assign ev    = (lev_s & ~r_sample & r_ren) | (~lev_s & r_sample & r_fen)
                 | (lev_s & r_hen) | (~lev_s & r_len);

    always_comb begin
        n_latch  = r_latch;
        n_sample = r_sample;
        n_status = r_status;
        n_ren    = r_ren;
        n_fen    = r_fen;
        n_hen    = r_hen;
        n_len    = r_len;
        if (i_item.opcode == OP_TICK) begin
            n_status = (r_status | ev) & PIN_MASK;
            n_sample = lev_s;
        end else if (wr) begin
            unique case (i_item.word_address)
                W_SET:   n_latch  = (r_latch | i_item.write_data) & PIN_MASK;
                W_CLR:   n_latch  = r_latch & ~i_item.write_data & PIN_MASK;
                W_EDS:   n_status = r_status & ~i_item.write_data & PIN_MASK;
                W_REN:   n_ren    = i_item.write_data & PIN_MASK;
                W_FEN:   n_fen    = i_item.write_data & PIN_MASK;
                W_HEN:   n_hen    = i_item.write_data & PIN_MASK;
                W_LEN:   n_len    = i_item.write_data & PIN_MASK;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_fsel = r_fsel;
        n_pull = r_pull;
        for (int p = 0; p < PIN_COUNT; p++) begin
            if (wr && i_item.word_address == 6'(p / FSEL_PINS_PER_WORD)) begin
                n_fsel[p] = i_item.write_data[3*(p % FSEL_PINS_PER_WORD) +: 3];
            end
            if (wr && i_item.word_address == W_PULL_LO + 6'(p / PULL_PINS_PER_WORD)) begin
                n_pull[p] = i_item.write_data[2*(p % PULL_PINS_PER_WORD) +: 2];
            end
        end
    end

    // register reads see unchanged state, so the current registers serve
    always_comb begin
        fsel_rd = '0;
        pull_rd = '0;
        for (int p = 0; p < PIN_COUNT; p++) begin
            if (i_item.word_address[1:0] == 2'(p / FSEL_PINS_PER_WORD)) begin
                fsel_rd[3*(p % FSEL_PINS_PER_WORD) +: 3] = r_fsel[p];
            end
            if ((i_item.word_address == W_PULL_HI) == 1'(p / PULL_PINS_PER_WORD)) begin
                pull_rd[2*(p % PULL_PINS_PER_WORD) +: 2] = r_pull[p];
            end
        end
    end

    always_comb begin
        rd = '0;
        if (i_item.opcode == OP_READ) begin
            unique case (i_item.word_address)
                W_FSEL0, W_FSEL1, W_FSEL2, W_FSEL3: rd = fsel_rd;
                W_LEV:                rd = r_sample;
                W_EDS:                rd = r_status;
                W_REN:                rd = r_ren;
                W_FEN:                rd = r_fen;
                W_HEN:                rd = r_hen;
                W_LEN:                rd = r_len;
                W_PULL_LO, W_PULL_HI: rd = pull_rd;
                default:              rd = '0;
            endcase
        end
    end

    always_comb begin
        oe    = '0;
        pulls = '0;
        for (int p = 0; p < PIN_COUNT; p++) begin
            oe[p]          = (n_fsel[p] == FSEL_OUTPUT);
            pulls[2*p +: 2] = n_pull[p];
        end
    end

    assign o_result.read_data         = rd;
    assign o_result.irq               = |n_status;
    assign o_result.pin_drive         = n_latch;
    assign o_result.pin_output_enable = oe;
    assign o_result.pad_pulls         = pulls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsel   <= '0;
            r_pull   <= '0;
            r_latch  <= '0;
            r_sample <= '0;
            r_status <= '0;
            r_ren    <= '0;
            r_fen    <= '0;
            r_hen    <= '0;
            r_len    <= '0;
        end else if (i_en) begin
            r_fsel   <= n_fsel;
            r_pull   <= n_pull;
            r_latch  <= n_latch;
            r_sample <= n_sample;
            r_status <= n_status;
            r_ren    <= n_ren;
            r_fen    <= n_fen;
            r_hen    <= n_hen;
            r_len    <= n_len;
        end
    end

`ifndef ASSERT_OFF
    a_status_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_status & ~PIN_MASK) == 32'd0)
        else $error("status set for absent pin");

    a_sample_only_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_item.opcode != OP_TICK) |=> r_sample == $past(r_sample))
        else $error("sample changed without tick");

    a_status_clear_eds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && !(wr && i_item.word_address == W_EDS))
        |=> (r_status & $past(r_status)) == $past(r_status))
        else $error("status cleared without status write");
`endif

endmodule

>>> hdl/gpio_port_with_event_detect.sv
// ----------------------------------------------------------------------------
// gpio_port_with_event_detect
// 32-pin register-mapped GPIO bank with edge and level event detection.
// ----------------------------------------------------------------------------
//  channel | dir | handshake                 | payload
//  item    | in  | i_in_valid / o_in_ready   | i_in_data  (t_item)
//  result  | out | o_out_valid / i_out_ready | o_out_data (t_result)
//
//  One transfer per cycle sustained while the result side accepts; each item
//  passes the input register, then the result register, before its result is offered.
//  Synchronous active-low reset clears the bank state and both valid flags;
//  the payload registers are not reset.
//  A stalled result holds the result register; the input register still
//  takes one more item, after which o_in_ready drops until the result moves.
// ----------------------------------------------------------------------------
module gpio_port_with_event_detect (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  gpe_pkg::t_item   i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output gpe_pkg::t_result o_out_data
);
    import gpe_pkg::*;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result result;
    logic    adv;

    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    gpe_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (adv),
        .i_item   (r_in),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (adv) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_adv_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> o_out_valid)
        else $error("result lost after advance");

    a_held_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !adv) |=> (r_in_valid && $stable(r_in)))
        else $error("pending item lost");

    a_ready_low_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && o_out_valid && !i_out_ready))
        else $error("input stalled without output stall");
`endif

endmodule

>>> dv/gpio_port_with_event_detect_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gpio_port_with_event_detect_tb
// Drives ticks, register reads, register writes and unused-opcode items into
// the GPIO bank. The sender works in bursts with random gaps and the result
// side stalls on its own pattern. A bit-accurate model of the bank predicts
// every result; results are checked per field against the oldest prediction.
// ----------------------------------------------------------------------------
module gpio_port_with_event_detect_tb;

    import gpe_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [5:0] W_SPARE   = 6'd63;
    localparam logic [5:0] W_HOLE    = 6'd40;
    localparam int unsigned RANDOM_ITEMS = 500;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    in_valid = 1'b0;
    t_item   in_item = '0;
    logic    out_ready = 1'b0;
    logic    o_in_ready;
    logic    o_out_valid;
    t_result o_out_data;

    // model of the bank state
    logic [2:0]  bank_fsel [32] = '{default: '0};
    logic [1:0]  bank_pull [32] = '{default: '0};
    logic [31:0] bank_latch  = '0;
    logic [31:0] bank_sample = '0;
    logic [31:0] bank_status = '0;
    logic [31:0] bank_rise   = '0;
    logic [31:0] bank_fall   = '0;
    logic [31:0] bank_high   = '0;
    logic [31:0] bank_low    = '0;

    t_item   pending_items [$];
    t_result expected_results [$];
    t_result want;
    int      mismatch_count = 0;
    int      burst_left = 0;
    int      gap_left = 0;
    int      stall_phase = 0;
    int      stall_mode = 0;

    gpio_port_with_event_detect u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_result gpio_bank_step(t_item it);
        t_result     r;
        logic [31:0] lv;
        logic [31:0] ev;
        int unsigned base;
        r = '0;
        case (it.opcode)
            OP_TICK: begin
                lv = it.pin_levels & PIN_MASK;
                ev = (lv & ~bank_sample & bank_rise) | (~lv & bank_sample & bank_fall)
                   | (lv & bank_high) | (~lv & bank_low);
                bank_status = (bank_status | ev) & PIN_MASK;
                bank_sample = lv;
            end
            OP_READ: begin
                if (it.word_address <= W_FSEL3) begin
                    base = it.word_address * FSEL_PINS_PER_WORD;
                    for (int k = 0; k < FSEL_PINS_PER_WORD; k++) begin
                        if (base + k < PIN_COUNT)
                            r.read_data |= 32'(bank_fsel[base + k]) << (3 * k);
                    end
                end else if (it.word_address == W_PULL_LO || it.word_address == W_PULL_HI) begin
                    base = (it.word_address - W_PULL_LO) * PULL_PINS_PER_WORD;
                    for (int k = 0; k < PULL_PINS_PER_WORD; k++) begin
                        if (base + k < PIN_COUNT)
                            r.read_data |= 32'(bank_pull[base + k]) << (2 * k);
                    end
                end else begin
                    case (it.word_address)
                        W_LEV:   r.read_data = bank_sample;
                        W_EDS:   r.read_data = bank_status;
                        W_REN:   r.read_data = bank_rise;
                        W_FEN:   r.read_data = bank_fall;
                        W_HEN:   r.read_data = bank_high;
                        W_LEN:   r.read_data = bank_low;
                        default: r.read_data = '0;
                    endcase
                end
            end
            OP_WRITE: begin
                if (it.word_address <= W_FSEL3) begin
                    base = it.word_address * FSEL_PINS_PER_WORD;
                    for (int k = 0; k < FSEL_PINS_PER_WORD; k++) begin
                        if (base + k < PIN_COUNT)
                            bank_fsel[base + k] = it.write_data[3 * k +: 3];
                    end
                end else if (it.word_address == W_PULL_LO || it.word_address == W_PULL_HI) begin
                    base = (it.word_address - W_PULL_LO) * PULL_PINS_PER_WORD;
                    for (int k = 0; k < PULL_PINS_PER_WORD; k++) begin
                        if (base + k < PIN_COUNT)
                            bank_pull[base + k] = it.write_data[2 * k +: 2];
                    end
                end else begin
                    case (it.word_address)
                        W_SET:   bank_latch = (bank_latch | it.write_data) & PIN_MASK;
                        W_CLR:   bank_latch = bank_latch & ~it.write_data & PIN_MASK;
                        W_EDS:   bank_status = bank_status & ~it.write_data & PIN_MASK;
                        W_REN:   bank_rise = it.write_data & PIN_MASK;
                        W_FEN:   bank_fall = it.write_data & PIN_MASK;
                        W_HEN:   bank_high = it.write_data & PIN_MASK;
                        W_LEN:   bank_low = it.write_data & PIN_MASK;
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        for (int p = 0; p < PIN_COUNT && p < 32; p++) begin
            r.pin_output_enable[p] = (bank_fsel[p] == FSEL_OUTPUT);
            r.pad_pulls |= 64'(bank_pull[p]) << (2 * p);
        end
        r.irq = |bank_status;
        r.pin_drive = bank_latch & PIN_MASK;
        return r;
    endfunction

    task automatic flag_mismatch(string field, logic [63:0] got, logic [63:0] exp_val);
        $display("%0t: MISMATCH %s: got %h, expected %h", $realtime, field, got, exp_val);
        mismatch_count++;
    endtask

    task automatic queue_item(logic [1:0] op, logic [5:0] addr, logic [31:0] data,
                              logic [31:0] levels);
        t_item it;
        it.opcode = op;
        it.word_address = addr;
        it.write_data = data;
        it.pin_levels = levels;
        pending_items.push_back(it);
    endtask

    // sender: bursts of transfers with random gaps between them
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            if (in_valid && o_in_ready)
                expected_results.push_back(gpio_bank_step(in_item));
            if (in_valid && !o_in_ready) begin
                // hold the offered item
            end else if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                in_item <= pending_items.pop_front();
                in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            stall_phase <= 0;
            stall_mode <= 0;
        end else begin
            if (stall_phase == 0) begin
                stall_mode <= $urandom_range(0, 3);
                stall_phase <= $urandom_range(8, 64);
            end else begin
                stall_phase <= stall_phase - 1;
            end
            case (stall_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 3) != 0);
                2:       out_ready <= (stall_phase % 5 < 2);
                default: out_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                flag_mismatch("unexpected result", 64'(o_out_data.read_data), '0);
            end else begin
                want = expected_results.pop_front();
                if (o_out_data.read_data !== want.read_data)
                    flag_mismatch("read_data", 64'(o_out_data.read_data),
                                  64'(want.read_data));
                if (o_out_data.irq !== want.irq)
                    flag_mismatch("irq", 64'(o_out_data.irq), 64'(want.irq));
                if (o_out_data.pin_drive !== want.pin_drive)
                    flag_mismatch("pin_drive", 64'(o_out_data.pin_drive),
                                  64'(want.pin_drive));
                if (o_out_data.pin_output_enable !== want.pin_output_enable)
                    flag_mismatch("pin_output_enable", 64'(o_out_data.pin_output_enable),
                                  64'(want.pin_output_enable));
                if (o_out_data.pad_pulls !== want.pad_pulls)
                    flag_mismatch("pad_pulls", o_out_data.pad_pulls, want.pad_pulls);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        t_item       it;
        logic [31:0] last_levels;
        int          sel;
        last_levels = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_item(OP_WRITE, W_FSEL0, 32'hFFFF_FFFF, '0);
        queue_item(OP_READ, W_FSEL0, '0, '0);
        queue_item(OP_WRITE, W_FSEL3, 32'hFFFF_FFC9, '0);
        queue_item(OP_READ, W_FSEL3, '0, '0);
        queue_item(OP_WRITE, W_FSEL1, 32'h0924_9249, '0);
        queue_item(OP_WRITE, W_SET, 32'hFFFF_FFFF, '0);
        queue_item(OP_WRITE, W_CLR, 32'h0F0F_0F0F, '0);
        queue_item(OP_READ, W_SET, '0, '0);
        queue_item(OP_WRITE, W_REN, 32'hFFFF_FFFF, '0);
        queue_item(OP_WRITE, W_FEN, 32'h0000_FFFF, '0);
        queue_item(OP_WRITE, W_HEN, 32'h00FF_0000, '0);
        queue_item(OP_WRITE, W_LEN, 32'h8000_0000, '0);
        queue_item(OP_TICK, '0, '0, 32'hFFFF_FFFF);
        queue_item(OP_READ, W_EDS, '0, '0);
        queue_item(OP_WRITE, W_EDS, 32'hFFFF_0000, '0);
        queue_item(OP_TICK, '0, '0, 32'h0000_0000);
        queue_item(OP_READ, W_LEV, '0, '0);
        queue_item(OP_WRITE, W_LEV, 32'hFFFF_FFFF, '0);
        queue_item(OP_WRITE, W_PULL_LO, 32'hFFFF_FFFF, '0);
        queue_item(OP_WRITE, W_PULL_HI, 32'hE4E4_E4E4, '0);
        queue_item(OP_READ, W_PULL_HI, '0, '0);
        queue_item(OP_UNUSED, W_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_item(OP_READ, W_SPARE, '0, '0);
        queue_item(OP_WRITE, W_HOLE, 32'hFFFF_FFFF, '0);
        queue_item(OP_WRITE, W_EDS, 32'hFFFF_FFFF, '0);
        queue_item(OP_READ, W_EDS, '0, '0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // pause the sender until the bank has fully drained
            if (n == 0 || n == RANDOM_ITEMS / 2) begin
                @(negedge i_clk);
                while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
                    @(negedge i_clk);
            end
            sel = $urandom_range(0, 19);
            it.opcode = (sel < 7) ? OP_TICK : (sel < 12) ? OP_READ :
                        (sel < 19) ? OP_WRITE : OP_UNUSED;
            case ($urandom_range(0, 13))
                0:       it.word_address = 6'($urandom_range(0, 3));
                1:       it.word_address = W_SET;
                2:       it.word_address = W_CLR;
                3:       it.word_address = W_LEV;
                4, 5:    it.word_address = W_EDS;
                6:       it.word_address = W_REN;
                7:       it.word_address = W_FEN;
                8:       it.word_address = W_HEN;
                9:       it.word_address = W_LEN;
                10:      it.word_address = W_PULL_LO;
                11:      it.word_address = W_PULL_HI;
                default: it.word_address = 6'($urandom_range(0, 63));
            endcase
            case ($urandom_range(0, 5))
                0:       it.write_data = '0;
                1:       it.write_data = '1;
                2:       it.write_data = 32'd1 << $urandom_range(0, 31);
                default: it.write_data = $urandom();
            endcase
            if (it.word_address <= W_FSEL3 && $urandom_range(0, 1) == 1) begin
                for (int k = 0; k < FSEL_PINS_PER_WORD; k++)
                    it.write_data[3 * k +: 3] = ($urandom_range(0, 2) == 0) ?
                                                3'($urandom()) : FSEL_OUTPUT;
            end
            if (it.word_address >= W_REN && it.word_address <= W_LEN && $urandom_range(0, 2) != 0)
                it.write_data = $urandom() & $urandom() & $urandom();
            case ($urandom_range(0, 5))
                0:       it.pin_levels = '0;
                1:       it.pin_levels = '1;
                2, 3:    it.pin_levels = last_levels ^ (32'd1 << $urandom_range(0, 31));
                default: it.pin_levels = $urandom();
            endcase
            if (it.opcode == OP_TICK)
                last_levels = it.pin_levels;
            pending_items.push_back(it);
        end

        @(negedge i_clk);
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
